// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PIP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define PIP_ASSERT(lbl, clk, rst_n, prop)
`define PIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/pip_pkg.sv
// Types and constants of the point-in-polygon test core.
`timescale 1ns / 1ps
package pip_pkg;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_ORIENT,
        ST_OWAIT,
        ST_FIN
    } t_state;

    // tag that rides along the cross-product pipeline
    typedef struct packed {
        logic orient;   // 1: orientation product, 0: edge test
        logic qual;     // edge spans the ray height
        logic dpos;     // edge runs upward
    } t_xp_tag;
endpackage

// File: hdl/point_in_polygon_test_core.sv
// Top level: vertex store, bounding box, edge walk and orientation control.
//
// channel  dir  tdata                              tuser
// s_axis   in   [31:0] coord_x, [63:32] coord_y     [1:0] cmd
// m_axis   out  [0] inside_res [1] direct [2] store_full, [7:3] zero
//
// A query with n stored vertices makes one RAM read per vertex from the
// single read port, then the three-stage cross-product pipeline drains,
// then the orientation product. With fewer than two vertices a query
// skips the walk and goes straight to the result.
// Synchronous active-low reset clears the count, box and flags; the store
// needs no clearing. A waiting result does not block the next word.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] coord_x, [63:32] coord_y
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] inside_res, [1] direct, [2] store_full
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CRD = pip_pkg::COORD_W;
    localparam int DW = pip_pkg::DIFF_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_VERTICES);

    pip_pkg::t_state r_state, n_state;

    logic [CW-1:0]         r_count, r_n;
    logic signed [CRD-1:0] r_bxl, r_bxh, r_byl, r_byh;
    logic                  r_drop;
    logic signed [CRD-1:0] r_px, r_py;
    logic                  r_inbox, r_odd, r_dir;
    logic [AW-1:0]         r_idx, r_didx, r_lo_idx;
    logic                  r_dv, r_su_pend;
    logic signed [CRD-1:0] r_prev_x, r_prev_y, r_v1_x, r_v1_y, r_vl_x, r_vl_y;
    logic signed [CRD-1:0] r_lo_x, r_lo_y, r_pr_x, r_pr_y, r_su_x, r_su_y;
    logic                  r_mvalid;
    logic [2:0]            r_mdata;

    logic                  in_fire, rd_en, xp_orient, fin;
    logic [1:0]            cmd;
    logic signed [CRD-1:0] in_x, in_y, rd_x, rd_y;
    logic [2*CRD-1:0]      ram_rdata;
    logic                  we;

    assign cmd     = s_axis_tuser;
    assign in_x    = $signed(s_axis_tdata[CRD-1:0]);
    assign in_y    = $signed(s_axis_tdata[2*CRD-1:CRD]);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == pip_pkg::ST_IDLE);
    assign we = in_fire && (cmd == pip_pkg::CMD_LOAD) && (r_count != MAXC);

    pip_ram #(.WIDTH(2 * CRD), .DEPTH(MAX_VERTICES)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({in_y, in_x}),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );
    assign rd_x = $signed(ram_rdata[CRD-1:0]);
    assign rd_y = $signed(ram_rdata[2*CRD-1:CRD]);

    // cross-product unit operands
    pip_pkg::t_xp_tag      xp_tag, xo_tag;
    logic                  xp_valid, xo_valid, xo_neg, xo_zero;
    logic signed [DW-1:0]  xa, xb, xc, xd;
    logic signed [CRD-1:0] e_lo, e_hi, o_pr_x, o_pr_y, o_su_x, o_su_y;

    always_comb begin
        e_lo = (r_prev_y < rd_y) ? r_prev_y : rd_y;
        e_hi = (r_prev_y < rd_y) ? rd_y : r_prev_y;
        o_pr_x = (r_lo_idx == AW'(1)) ? r_vl_x : r_pr_x;
        o_pr_y = (r_lo_idx == AW'(1)) ? r_vl_y : r_pr_y;
        o_su_x = (CW'(r_lo_idx) == r_n - CW'(1)) ? r_v1_x : r_su_x;
        o_su_y = (CW'(r_lo_idx) == r_n - CW'(1)) ? r_v1_y : r_su_y;
        xp_valid = (r_dv && (r_didx != '0)) || xp_orient;
        if (xp_orient) begin
            xp_tag = '{orient: 1'b1, qual: 1'b0, dpos: 1'b0};
            xa = DW'(o_su_x) - DW'(r_lo_x);
            xb = DW'(o_pr_y) - DW'(r_lo_y);
            xc = DW'(r_lo_y) - DW'(o_su_y);
            xd = DW'(o_pr_x) - DW'(r_lo_x);
        end else begin
            xp_tag.orient = 1'b0;
            xp_tag.qual   = (r_py >= e_lo) && (r_py <= e_hi) && (r_prev_y != rd_y)
                            && (r_py != r_prev_y);
            xp_tag.dpos   = (rd_y > r_prev_y);
            xa = DW'(r_prev_x) - DW'(r_px);
            xb = DW'(rd_y) - DW'(r_prev_y);
            xc = DW'(r_py) - DW'(r_prev_y);
            xd = DW'(rd_x) - DW'(r_prev_x);
        end
    end

    pip_xprod u_xprod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xp_valid),
        .i_tag   (xp_tag),
        .i_a     (xa),
        .i_b     (xb),
        .i_c     (xc),
        .i_d     (xd),
        .o_valid (xo_valid),
        .o_tag   (xo_tag),
        .o_neg   (xo_neg),
        .o_zero  (xo_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pip_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        xp_orient = 1'b0;
        fin       = 1'b0;
        unique case (r_state)
            pip_pkg::ST_IDLE: begin
                if (in_fire && (cmd == pip_pkg::CMD_QUERY)) begin
                    n_state = (r_count < CW'(2)) ? pip_pkg::ST_FIN : pip_pkg::ST_WALK;
                end
            end
            pip_pkg::ST_WALK: begin
                rd_en = 1'b1;
                if (CW'(r_idx) == r_n - CW'(1)) begin
                    n_state = pip_pkg::ST_DRAIN;
                end
            end
            pip_pkg::ST_DRAIN: begin
                n_state = pip_pkg::ST_ORIENT;
            end
            pip_pkg::ST_ORIENT: begin
                xp_orient = 1'b1;
                n_state   = pip_pkg::ST_OWAIT;
            end
            pip_pkg::ST_OWAIT: begin
                if (xo_valid && xo_tag.orient) begin
                    n_state = pip_pkg::ST_FIN;
                end
            end
            pip_pkg::ST_FIN: begin
                if (!r_mvalid || m_axis_tready) begin
                    fin     = 1'b1;
                    n_state = pip_pkg::ST_IDLE;
                end
            end
            default: n_state = pip_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_bxl    <= {1'b0, {(CRD-1){1'b1}}};
            r_byl    <= {1'b0, {(CRD-1){1'b1}}};
            r_bxh    <= {1'b1, {(CRD-1){1'b0}}};
            r_byh    <= {1'b1, {(CRD-1){1'b0}}};
            r_dv     <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_dv <= rd_en;
            if (in_fire && (cmd == pip_pkg::CMD_CLEAR)) begin
                r_count <= '0;
                r_drop  <= 1'b0;
                r_bxl   <= {1'b0, {(CRD-1){1'b1}}};
                r_byl   <= {1'b0, {(CRD-1){1'b1}}};
                r_bxh   <= {1'b1, {(CRD-1){1'b0}}};
                r_byh   <= {1'b1, {(CRD-1){1'b0}}};
            end else if (in_fire && (cmd == pip_pkg::CMD_LOAD)) begin
                if (r_count == MAXC) begin
                    r_drop <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                    if (in_x < r_bxl) r_bxl <= in_x;
                    if (in_x > r_bxh) r_bxh <= in_x;
                    if (in_y < r_byl) r_byl <= in_y;
                    if (in_y > r_byh) r_byh <= in_y;
                end
            end
            if (fin) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        if (in_fire && (cmd == pip_pkg::CMD_QUERY)) begin
            r_px    <= in_x;
            r_py    <= in_y;
            r_n     <= r_count;
            r_idx   <= '0;
            r_odd   <= 1'b0;
            r_dir   <= 1'b0;
            r_inbox <= (in_x >= r_bxl) && (in_x <= r_bxh)
                       && (in_y >= r_byl) && (in_y <= r_byh);
        end else if (rd_en) begin
            r_idx <= r_idx + AW'(1);
        end
        r_didx <= r_idx;
        if (r_dv) begin
            r_prev_x <= rd_x;
            r_prev_y <= rd_y;
            r_vl_x   <= rd_x;
            r_vl_y   <= rd_y;
            if (r_didx == AW'(1)) begin
                r_v1_x <= rd_x;
                r_v1_y <= rd_y;
            end
            // first strict minimum of y over v[1..n-1]
            if (r_didx != '0) begin
                if ((r_didx == AW'(1)) || (rd_y < r_lo_y)) begin
                    r_lo_idx  <= r_didx;
                    r_lo_x    <= rd_x;
                    r_lo_y    <= rd_y;
                    r_pr_x    <= r_prev_x;
                    r_pr_y    <= r_prev_y;
                    r_su_pend <= 1'b1;
                end else if (r_su_pend) begin
                    r_su_x    <= rd_x;
                    r_su_y    <= rd_y;
                    r_su_pend <= 1'b0;
                end
            end
        end
        if (xo_valid) begin
            if (xo_tag.orient) begin
                r_dir <= !xo_neg && !xo_zero;
            end else if (xo_tag.qual && (xo_tag.dpos ? (!xo_neg && !xo_zero) : xo_neg)) begin
                r_odd <= !r_odd;
            end
        end
        if (fin) begin
            r_mdata <= {r_drop, r_dir, r_inbox && r_odd};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {5'b0, r_mdata};

    `PIP_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= MAXC)
    `PIP_ASSERT_IMPL(a_walk_two, i_clk, i_rst_n, r_state == pip_pkg::ST_WALK, r_n >= CW'(2))
    `PIP_ASSERT_IMPL(a_idle_flushed, i_clk, i_rst_n, r_state == pip_pkg::ST_IDLE, !xo_valid)
    `PIP_ASSERT_IMPL(a_read_walk, i_clk, i_rst_n, r_dv, $past(r_state) == pip_pkg::ST_WALK)
endmodule

// File: hdl/pip_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/pip_xprod.sv
// Pipelined sign of a*b + c*d on 33-bit signed operands.
`timescale 1ns / 1ps
module pip_xprod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  pip_pkg::t_xp_tag                  i_tag,
    input  logic signed [pip_pkg::DIFF_W-1:0] i_a,
    input  logic signed [pip_pkg::DIFF_W-1:0] i_b,
    input  logic signed [pip_pkg::DIFF_W-1:0] i_c,
    input  logic signed [pip_pkg::DIFF_W-1:0] i_d,
    output logic                              o_valid,
    output pip_pkg::t_xp_tag                  o_tag,
    output logic                              o_neg,
    output logic                              o_zero
);
    logic                              r_v0, r_v1, r_v2;
    pip_pkg::t_xp_tag                  r_t0, r_t1, r_t2;
    logic signed [pip_pkg::DIFF_W-1:0] r_a, r_b, r_c, r_d;
    logic signed [pip_pkg::PROD_W-1:0] r_p1, r_p2;
    logic signed [pip_pkg::SUM_W-1:0]  r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0  <= i_tag;
        r_a   <= i_a;
        r_b   <= i_b;
        r_c   <= i_c;
        r_d   <= i_d;
        r_t1  <= r_t0;
        r_p1  <= r_a * r_b;
        r_p2  <= r_c * r_d;
        r_t2  <= r_t1;
        r_sum <= pip_pkg::SUM_W'(r_p1) + pip_pkg::SUM_W'(r_p2);
    end

    assign o_valid = r_v2;
    assign o_tag   = r_t2;
    assign o_neg   = r_sum[pip_pkg::SUM_W-1];
    assign o_zero  = (r_sum == '0);
endmodule
